FILE: sv/rdmi_pkg.sv
package rdmi_pkg;

  localparam int unsigned PixW = 16;
  localparam int unsigned KeyW = 12;
  localparam int unsigned BoostW = 12;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [15:0] CacheEmpty = 16'hFFFF;
  localparam logic [15:0] CacheWhite = 16'hFFFE;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInvertMode = 1'b0,
    CfgSatBoost   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] pixel;
    logic        last;
    logic        smart;
    logic [11:0] key;
  } job_t;

  function automatic logic [11:0] key_of(logic [15:0] p);
    return {p[15:12], p[10:7], p[4:1]};
  endfunction

  function automatic logic [15:0] plain_invert(logic [15:0] p);
    logic [7:0] r8, g8, b8;
    r8 = ~{p[15:11], p[15:13]};
    g8 = ~{p[10:5], p[10:9]};
    b8 = ~{p[4:0], p[4:2]};
    return {r8[7:3], g8[7:2], b8[7:3]};
  endfunction

endpackage

FILE: sv/rdmi_if.sv
interface rdmi_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_in;
  logic        frame_last;
  modport source (output valid, pixel_in, frame_last, input ready);
  modport sink (input valid, pixel_in, frame_last, output ready);
endinterface

interface rdmi_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;
  logic        cache_hit;
  logic        frame_end;
  modport source (output valid, pixel_out, cache_hit, frame_end, input ready);
  modport sink (input valid, pixel_out, cache_hit, frame_end, output ready);
endinterface

interface rdmi_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/rdmi_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
module rdmi_divider import rdmi_pkg::*; #(
  parameter int unsigned NumW = 24,
  parameter int unsigned DenW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

FILE: sv/rdmi_front.sv
// Accepts words, tags each with the current mode and hands jobs to the queue.
module rdmi_front import rdmi_pkg::*; (
  rdmi_in_if.sink      in_if,
  input  logic         mode_i,
  input  logic         q_full_i,
  output logic         push_o,
  output job_t         job_o
);
  assign in_if.ready = !q_full_i;
  assign push_o = in_if.valid && !q_full_i;
  assign job_o = '{pixel: in_if.pixel_in, last: in_if.frame_last, smart: mode_i,
                   key: key_of(in_if.pixel_in)};
endmodule

FILE: sv/rdmi_queue.sv
module rdmi_queue import rdmi_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output job_t job_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  function automatic logic [PtrW-1:0] inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (pop_i) rd_q <= inc(rd_q);
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  assign full_o = cnt_q == (PtrW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign job_o = mem_q[rd_q];

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("queue underflow");
endmodule

FILE: sv/rdmi_back.sv
// Plain invert, or cache lookup with smart compute on a miss; drives the output register.
module rdmi_back import rdmi_pkg::*; #(
  parameter int unsigned FracBits = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  job_t              job_i,
  output logic              pop_o,
  input  logic [BoostW-1:0] boost_i,
  output logic              busy_o,
  rdmi_out_if.source        out_if
);
  localparam int unsigned F = FracBits;
  localparam int unsigned QW = F + 12;
  localparam logic [F+2:0] One = (F+3)'(1) << F;

  typedef enum logic [3:0] {
    StClear, StIdle, StRead, StLook, StS, StSWait, StH, StHWait, StMix1, StMix2,
    StMix3, StChan, StOut
  } state_e;

  state_e state_q;
  logic [KeyW-1:0] clr_q;
  logic [15:0] cache [1 << KeyW];
  logic [15:0] rd_q;
  logic [15:0] cache_wdata;
  logic [KeyW-1:0] cache_waddr;
  logic        cache_we;

  job_t        job_q;
  logic [7:0]  r_q, g_q, b_q, mx_q, mn_q, d_q;
  logic [8:0]  sum_q;
  logic [1:0]  sel_q;
  logic        neg_q;
  logic [F:0]  l_q, s_q;
  logic [F+2:0] hp_q;
  logic [F:0]  s2_q, c_q, x_q;
  logic [15:0] res_q;
  logic        ovalid_q, ohit_q, olast_q;

  logic        div_start, div_done;
  logic [QW-1:0] div_num, div_quo;
  logic [9:0]  div_den;

  rdmi_divider #(.NumW(QW), .DenW(10)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic [7:0] wr8, wg8, wb8;
  assign wr8 = {job_q.pixel[15:11], job_q.pixel[15:13]};
  assign wg8 = {job_q.pixel[10:5], job_q.pixel[10:9]};
  assign wb8 = {job_q.pixel[4:0], job_q.pixel[4:2]};

  logic [8:0] dsum, dden;
  assign dsum = sum_q;
  assign dden = (sum_q > 9'd255) ? 9'd510 - sum_q : sum_q;

  logic [23:0] l_m;
  logic [47:0] l_prod;
  assign l_m = (24'(dsum) << (F - 1)) + 24'd127;
  assign l_prod = 48'(l_m) * 48'h808081;

  logic [7:0] hnum;
  always_comb begin
    case (sel_q)
      2'd0: hnum = (g_q >= b_q) ? g_q - b_q : b_q - g_q;
      2'd1: hnum = (b_q >= r_q) ? b_q - r_q : r_q - b_q;
      default: hnum = (r_q >= g_q) ? r_q - g_q : g_q - r_q;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    if (state_q == StS) begin
      div_start = 1'b1;
      div_num = QW'({d_q, {(F + 1){1'b0}}}) + QW'(dden);
      div_den = {dden, 1'b0};
    end else if (state_q == StH) begin
      div_start = 1'b1;
      div_num = QW'({hnum, {(F + 1){1'b0}}}) + QW'(d_q);
      div_den = {1'b0, d_q, 1'b0};
    end
  end

  // Combinational pieces of the HSL-to-RGB back end.
  logic [F+1:0]  two_l;
  logic [F:0]    t_abs, hm_abs;
  logic [F+2:0]  hm;
  logic [F+13:0] s2_full;
  logic [2*F+2:0] c_prod, x_prod;
  logic [2:0]    sec;
  logic [F:0]    v_r, v_g, v_b;

  assign two_l = {l_q, 1'b0};
  assign t_abs = (two_l >= (F+2)'(One)) ? (F+1)'(two_l - (F+2)'(One))
                                         : (F+1)'((F+2)'(One) - two_l);
  assign hm = (hp_q >= (One << 1)) ? ((hp_q >= (One << 2)) ? hp_q - (One << 2)
                                                          : hp_q - (One << 1)) : hp_q;
  assign hm_abs = (hm >= One) ? (F+1)'(hm - One) : (F+1)'(One - hm);
  assign s2_full = (F+14)'(s_q) * (F+14)'(boost_i) + (F+14)'(128);
  assign c_prod = (2*F+3)'((F+1)'(One) - t_abs) * (2*F+3)'(s2_q) + (2*F+3)'(One >> 1);
  assign x_prod = (2*F+3)'(c_q) * (2*F+3)'((F+1)'(One) - hm_abs) + (2*F+3)'(One >> 1);
  assign sec = hp_q[F+2:F];

  always_comb begin
    v_r = '0; v_g = '0; v_b = '0;
    case (sec)
      3'd0: begin v_r = c_q; v_g = x_q; end
      3'd1: begin v_r = x_q; v_g = c_q; end
      3'd2: begin v_g = c_q; v_b = x_q; end
      3'd3: begin v_g = x_q; v_b = c_q; end
      3'd4: begin v_r = x_q; v_b = c_q; end
      default: begin v_r = c_q; v_b = x_q; end
    endcase
  end

  function automatic logic [7:0] chan(logic [F:0] v, logic [F+1:0] l2, logic [F:0] c);
    logic signed [F+3:0] n;
    logic [F+12:0] o;
    n = $signed({2'b0, v, 1'b0}) + $signed({2'b0, l2}) - $signed({3'b0, c});
    if (n < 0) n = '0;
    o = ((F+13)'(unsigned'(n)) * (F+13)'(255) + (F+13)'(One)) >> (F + 1);
    return (o > (F+13)'(255)) ? 8'd255 : o[7:0];
  endfunction

  logic [7:0] cr, cg, cb;
  assign cr = chan(v_r, two_l, c_q);
  assign cg = chan(v_g, two_l, c_q);
  assign cb = chan(v_b, two_l, c_q);

  logic out_free, out_load;
  assign out_free = !ovalid_q || out_if.ready;
  assign pop_o = (state_q == StIdle) && !empty_i && out_free;
  assign out_load = (pop_o && !job_i.smart) || (state_q == StOut && out_free);

  always_comb begin
    cache_we = 1'b0;
    cache_waddr = job_q.key;
    cache_wdata = (res_q == CacheEmpty) ? CacheWhite : res_q;
    if (state_q == StClear) begin
      cache_we = 1'b1;
      cache_waddr = clr_q;
      cache_wdata = CacheEmpty;
    end else if (state_q == StOut && !ohit_q) begin
      cache_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cache_we) cache[cache_waddr] <= cache_wdata;
    rd_q <= cache[job_q.key];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (out_load) ovalid_q <= 1'b1;
      else if (out_if.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= StIdle;
        end
        StIdle: begin
          if (pop_o) begin
            job_q <= job_i;
            if (job_i.smart) begin
              state_q <= StRead;
            end else begin
              res_q <= plain_invert(job_i.pixel);
              ohit_q <= 1'b0;
              olast_q <= job_i.last;
            end
          end
        end
        StRead: state_q <= StLook;
        StLook: begin
          r_q <= wr8; g_q <= wg8; b_q <= wb8;
          if (rd_q != CacheEmpty) begin
            res_q <= rd_q;
            ohit_q <= 1'b1;
            state_q <= StOut;
          end else begin
            ohit_q <= 1'b0;
            state_q <= StS;
          end
          begin
            logic [7:0] mx, mn;
            mx = wr8; if (wg8 > mx) mx = wg8; if (wb8 > mx) mx = wb8;
            mn = wr8; if (wg8 < mn) mn = wg8; if (wb8 < mn) mn = wb8;
            mx_q <= mx; mn_q <= mn; d_q <= mx - mn;
            sum_q <= {1'b0, mx} + {1'b0, mn};
            if (mx == wr8) begin
              sel_q <= 2'd0; neg_q <= wg8 < wb8;
            end else if (mx == wg8) begin
              sel_q <= 2'd1; neg_q <= wb8 < wr8;
            end else begin
              sel_q <= 2'd2; neg_q <= wr8 < wg8;
            end
          end
        end
        StS: begin
          // Lightness round(sum*ONE/510): halve, then divide by 255 through its reciprocal.
          l_q <= (F+1)'(l_prod >> 31);
          if (d_q == '0) begin
            s_q <= '0;
            hp_q <= '0;
            state_q <= StMix1;
          end else begin
            state_q <= StSWait;
          end
        end
        StSWait: if (div_done) begin
          s_q <= (F+1)'(div_quo);
          state_q <= StH;
        end
        StH: begin
          l_q <= (F+1)'(One) - l_q;
          state_q <= StHWait;
        end
        StHWait: if (div_done) begin
          logic [F+2:0] base, q;
          q = (F+3)'(div_quo);
          base = (sel_q == 2'd0) ? '0 : (sel_q == 2'd1) ? (One << 1) : (One << 2);
          if (neg_q) begin
            if (sel_q == 2'd0) hp_q <= (F+3)'(6 << F) - q;
            else hp_q <= (base >= q) ? base - q : '0;
          end else begin
            hp_q <= base + q;
          end
          state_q <= StMix1;
        end
        StMix1: begin
          if (d_q == '0) l_q <= (F+1)'(One) - l_q;
          s2_q <= (s2_full[F+13:8] > (F+6)'(One)) ? (F+1)'(One) : (F+1)'(s2_full[F+13:8]);
          state_q <= StMix2;
        end
        StMix2: begin
          c_q <= (F+1)'(c_prod >> F);
          state_q <= StMix3;
        end
        StMix3: begin
          x_q <= (F+1)'(x_prod >> F);
          state_q <= StChan;
        end
        StChan: begin
          res_q <= {cr[7:3], cg[7:2], cb[7:3]};
          state_q <= StOut;
        end
        StOut: begin
          if (out_free) begin
            olast_q <= job_q.last;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = state_q != StIdle || ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.pixel_out = res_q;
  assign out_if.cache_hit = ohit_q;
  assign out_if.frame_end = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_if.ready |=> ovalid_q && $stable(res_q))
    else $error("output word lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClear |-> !pop_o)
    else $error("pop during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> state_q == StS || state_q == StH)
    else $error("stray divider start");
endmodule

FILE: sv/rgb565_dark_mode_invert_core.sv
// Plain mode: queue, then output register; one word per cycle when unstalled.
// Smart mode, cache hit: StRead, StLook (registered cache read) and StOut, then back to idle.
// Smart mode, miss: saturation and hue divisions on the shared bit-serial divider (skipped
// for grey), then StMix1 to StMix3, StChan and StOut; smart words are taken one at a time.
// After reset the cache is cleared entry by entry; the input stalls once the queue fills.
// Reset sets invert_mode to 0 and sat_boost to 256.
module rgb565_dark_mode_invert_core import rdmi_pkg::*; #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rdmi_cfg_if.sink    cfg,
  rdmi_in_if.sink     in_ch,
  rdmi_out_if.source  out_ch
);
  logic              mode_q;
  logic [BoostW-1:0] boost_q;
  logic              push, pop, full, empty, busy;
  job_t              job_in, job_out;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      boost_q <= BoostW'(256);
    end else if (cfg.valid) begin
      unique case (cfg_idx_e'(cfg.index))
        CfgInvertMode: mode_q <= cfg.data[0];
        CfgSatBoost:   boost_q <= cfg.data;
        default: ;
      endcase
    end
  end

  rdmi_front u_front (
    .in_if(in_ch), .mode_i(mode_q), .q_full_i(full),
    .push_o(push), .job_o(job_in)
  );

  rdmi_queue #(.Depth(2)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in), .full_o(full), .empty_o(empty),
    .pop_i(pop), .job_o(job_out)
  );

  rdmi_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .job_i(job_out), .pop_o(pop),
    .boost_i(boost_q), .busy_o(busy), .out_if(out_ch)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("output valid dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && empty |-> !out_ch.valid)
    else $error("output valid while idle");
endmodule
